/* rtl/osu_pkg.sv */
// ----------------------------------------------------------------------------
// osu_pkg
// Shared types and constants for the oversampled UART transceiver: item and
// result words, configuration register map, status bundles between units.
// ----------------------------------------------------------------------------
package osu_pkg;

  localparam int TX_DEPTH_DEF   = 16;
  localparam int OVERSAMPLE_DEF = 5;

  localparam logic [3:0] MAX_DATA_BITS = 4'd8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CFG_DATA_BITS    = 3'd0,
    CFG_PARITY_ODD   = 3'd1,
    CFG_PARITY_END   = 3'd2,
    CFG_FRAME_END    = 3'd3,
    CFG_RX_IDLE_BITS = 3'd4,
    CFG_LINE_INVERT  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rx_level;
    logic [7:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_level;
    logic       tx_busy;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_busy;
    logic       rx_done;
    logic       cmd_error;
  } result_t;

  typedef struct packed {
    logic [3:0] data_bits;
    logic       parity_odd;
    logic [3:0] parity_end;
    logic [3:0] frame_end;
    logic [7:0] rx_idle_bits;
    logic       line_invert;
  } cfg_t;

  typedef struct packed {
    logic pin;
    logic active;
    logic cmd_error;
  } tx_stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       busy;
    logic       done;
  } rx_stat_t;

  function automatic logic [3:0] eff_bits(input logic [3:0] data_bits);
    return (data_bits > MAX_DATA_BITS) ? MAX_DATA_BITS : data_bits;
  endfunction

endpackage

/* rtl/osu_cfg.sv */
// ----------------------------------------------------------------------------
// osu_cfg
// Configuration register file; write-only, indexed by the register map.
// ----------------------------------------------------------------------------
module osu_cfg
  import osu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_bits    <= 4'd8;
      cfg.parity_odd   <= 1'b0;
      cfg.parity_end   <= 4'd9;
      cfg.frame_end    <= 4'd10;
      cfg.rx_idle_bits <= 8'd10;
      cfg.line_invert  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_BITS:    cfg.data_bits    <= cfg_data[3:0];
        CFG_PARITY_ODD:   cfg.parity_odd   <= cfg_data[0];
        CFG_PARITY_END:   cfg.parity_end   <= cfg_data[3:0];
        CFG_FRAME_END:    cfg.frame_end    <= cfg_data[3:0];
        CFG_RX_IDLE_BITS: cfg.rx_idle_bits <= cfg_data;
        CFG_LINE_INVERT:  cfg.line_invert  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/osu_tx.sv */
// ----------------------------------------------------------------------------
// osu_tx
// Transmit buffer and bit sequencer: load and start commands, one bit slot
// per phase-zero tick, parity and stop generation.
// ----------------------------------------------------------------------------
module osu_tx
  import osu_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [1:0] op,
  input  logic [7:0] tx_byte,
  input  logic       phase_zero,
  output tx_stat_t   status
);

  localparam int CW = $clog2(TX_DEPTH + 1);
  localparam int AW = $clog2(TX_DEPTH);
  localparam logic [CW-1:0] DEPTH = CW'(TX_DEPTH);

  logic [7:0]    mem [TX_DEPTH];
  logic [7:0]    rd_data;

  logic [3:0]    slot, slot_next;
  logic [2:0]    shift, shift_next;
  logic          ones_parity, ones_parity_next;
  logic          active, active_next;
  logic [CW-1:0] read_index, read_index_next;
  logic [CW-1:0] count, count_next;
  logic          pin, pin_next;
  logic          err;
  logic          mem_we;
  logic [3:0]    eff;

  assign eff = eff_bits(cfg.data_bits);

  always_comb begin
    logic          b;
    logic [CW-1:0] ri;
    b                = rd_data[shift];
    ri               = read_index + CW'(1);
    slot_next        = slot;
    shift_next       = shift;
    ones_parity_next = ones_parity;
    active_next      = active;
    read_index_next  = read_index;
    count_next       = count;
    pin_next         = pin;
    err              = 1'b0;
    mem_we           = 1'b0;
    case (op)
      OP_TICK: begin
        if (phase_zero && active) begin
          if (slot == 4'd0) begin
            shift_next       = 3'd0;
            ones_parity_next = 1'b0;
            slot_next        = 4'd1;
            pin_next         = 1'b0;
          end else if (slot < eff + 4'd1) begin
            pin_next         = b;
            ones_parity_next = ones_parity ^ b;
            slot_next        = slot + 4'd1;
            shift_next       = shift + 3'd1;
          end else if (slot < cfg.parity_end) begin
            pin_next  = ones_parity ^ cfg.parity_odd;
            slot_next = slot + 4'd1;
          end else if (slot < cfg.frame_end) begin
            pin_next  = 1'b1;
            slot_next = slot + 4'd1;
          end else begin
            slot_next       = 4'd0;
            read_index_next = ri;
            if (ri >= count) begin
              active_next     = 1'b0;
              read_index_next = '0;
              count_next      = '0;
            end
          end
        end
      end
      OP_LOAD: begin
        if (active || count >= DEPTH) begin
          err = 1'b1;
        end else begin
          mem_we     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_START: begin
        if (active || count == '0) begin
          err = 1'b1;
        end else begin
          active_next     = 1'b1;
          read_index_next = '0;
          slot_next       = 4'd0;
        end
      end
      default: err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= 4'd0;
      shift       <= 3'd0;
      ones_parity <= 1'b0;
      active      <= 1'b0;
      read_index  <= '0;
      count       <= '0;
      pin         <= 1'b1;
    end else if (step) begin
      slot        <= slot_next;
      shift       <= shift_next;
      ones_parity <= ones_parity_next;
      active      <= active_next;
      read_index  <= read_index_next;
      count       <= count_next;
      pin         <= pin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && mem_we) begin
      mem[count[AW-1:0]] <= tx_byte;
    end
    rd_data <= mem[read_index[AW-1:0]];
  end

  assign status.pin       = pin_next;
  assign status.active    = active_next;
  assign status.cmd_error = err;

endmodule

/* rtl/osu_rx.sv */
// ----------------------------------------------------------------------------
// osu_rx
// Receive sequencer: phase lock on the start bit, data assembly, stop check
// and idle wait before completion.
// ----------------------------------------------------------------------------
module osu_rx
  import osu_pkg::*;
#(
  parameter int OVERSAMPLE = OVERSAMPLE_DEF
)
(
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          step_tick,
  input  logic [$clog2(OVERSAMPLE)-1:0] phase,
  input  logic                          level,
  output rx_stat_t                      status
);

  localparam int PW = $clog2(OVERSAMPLE);
  localparam logic [PW:0] HALF = (PW+1)'(OVERSAMPLE / 2);
  localparam logic [PW:0] MODV = (PW+1)'(OVERSAMPLE);

  logic [3:0]    slot, slot_next;
  logic [7:0]    cnt, cnt_next;
  logic [7:0]    assembly, assembly_next;
  logic          busy, busy_next;
  logic          wait_idle, wait_idle_next;
  logic          done, done_next;
  logic          locked, locked_next;
  logic [PW-1:0] sample_phase, sample_phase_next;
  logic          got_byte;
  logic [PW:0]   mid_sum;
  logic [PW-1:0] mid_phase;
  logic [3:0]    eff;

  assign eff       = eff_bits(cfg.data_bits);
  assign mid_sum   = {1'b0, phase} + HALF;
  assign mid_phase = (mid_sum >= MODV) ? PW'(mid_sum - MODV) : PW'(mid_sum);

  always_comb begin
    slot_next         = slot;
    cnt_next          = cnt;
    assembly_next     = assembly;
    busy_next         = busy;
    wait_idle_next    = wait_idle;
    done_next         = done;
    locked_next       = locked;
    sample_phase_next = sample_phase;
    got_byte          = 1'b0;
    if (!locked && slot == 4'd0 && !level) begin
      sample_phase_next = mid_phase;
      locked_next       = 1'b1;
    end else if (locked && sample_phase == phase) begin
      if (slot == 4'd0 || wait_idle) begin
        if (!level) begin
          busy_next      = 1'b1;
          wait_idle_next = 1'b0;
          done_next      = 1'b0;
          cnt_next       = 8'd0;
          slot_next      = 4'd1;
          assembly_next  = 8'd0;
        end else if (wait_idle) begin
          if (cnt < cfg.rx_idle_bits) begin
            cnt_next = cnt + 8'd1;
          end else begin
            wait_idle_next = 1'b0;
            busy_next      = 1'b0;
            done_next      = 1'b1;
            locked_next    = 1'b0;
          end
        end else begin
          locked_next = 1'b0;
        end
      end else if (slot < eff + 4'd1) begin
        assembly_next[cnt[2:0]] = assembly[cnt[2:0]] | level;
        slot_next               = slot + 4'd1;
        cnt_next                = cnt + 8'd1;
      end else if (slot < cfg.parity_end) begin
        slot_next = slot + 4'd1;
      end else begin
        cnt_next       = 8'd0;
        slot_next      = 4'd0;
        wait_idle_next = 1'b1;
        got_byte       = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot         <= 4'd0;
      cnt          <= 8'd0;
      assembly     <= 8'd0;
      busy         <= 1'b0;
      wait_idle    <= 1'b0;
      done         <= 1'b0;
      locked       <= 1'b0;
      sample_phase <= '0;
    end else if (step_tick) begin
      slot         <= slot_next;
      cnt          <= cnt_next;
      assembly     <= assembly_next;
      busy         <= busy_next;
      wait_idle    <= wait_idle_next;
      done         <= done_next;
      locked       <= locked_next;
      sample_phase <= sample_phase_next;
    end
  end

  assign status.valid = step_tick && got_byte;
  assign status.data  = (step_tick && got_byte) ? assembly : 8'd0;
  assign status.busy  = step_tick ? busy_next : busy;
  assign status.done  = step_tick ? done_next : done;

endmodule

/* rtl/oversampled_soft_uart.sv */
// An accepted item passes through the input register, then the result register;
// one item per cycle sustained while result_stall does not hold the output.
// The line engines update their state as each item advances between the two registers.
// Reset (rst, synchronous) idles both line engines, empties the transmit buffer
// and restores the register defaults; buffer contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// oversampled_soft_uart
// UART transceiver stepped by an oversampling tick, with a transmit buffer
// filled and launched by load and start words.
// ----------------------------------------------------------------------------
module oversampled_soft_uart
  import osu_pkg::*;
#(
  parameter int TX_DEPTH   = TX_DEPTH_DEF,
  parameter int OVERSAMPLE = OVERSAMPLE_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int PW = $clog2(OVERSAMPLE);
  localparam logic [PW-1:0] PHASE_LAST = PW'(OVERSAMPLE - 1);

  cfg_t          cfg;
  logic          s1_valid;
  item_t         s1;
  logic          adv;
  logic          step_tick;
  logic [PW-1:0] phase;
  tx_stat_t      tx_stat;
  rx_stat_t      rx_stat;

  assign adv        = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !adv;
  assign step_tick  = adv && (s1.op == OP_TICK);

  osu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  osu_tx #(
    .TX_DEPTH (TX_DEPTH)
  ) u_tx (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (adv),
    .op         (s1.op),
    .tx_byte    (s1.tx_byte),
    .phase_zero (phase == '0),
    .status     (tx_stat)
  );

  osu_rx #(
    .OVERSAMPLE (OVERSAMPLE)
  ) u_rx (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step_tick (step_tick),
    .phase     (phase),
    .level     (s1.rx_level ^ cfg.line_invert),
    .status    (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (step_tick) begin
      phase <= (phase == PHASE_LAST) ? '0 : phase + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.tx_level  <= tx_stat.pin ^ cfg.line_invert;
      result.tx_busy   <= tx_stat.active;
      result.rx_valid  <= rx_stat.valid;
      result.rx_data   <= rx_stat.data;
      result.rx_busy   <= rx_stat.busy;
      result.rx_done   <= rx_stat.done;
      result.cmd_error <= tx_stat.cmd_error;
    end
  end

  a_adv_fills_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> result_valid)
    else $error("result register not loaded after advance");

  a_tick_no_error: assert property (@(posedge clk) disable iff (rst)
    (adv && s1.op == OP_TICK) |=> !result.cmd_error)
    else $error("command error raised on a tick");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PHASE_LAST)
    else $error("tick phase out of range");

  a_byte_while_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.rx_valid) |-> result.rx_busy)
    else $error("received byte outside a busy frame");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.rx_done) |-> !result.rx_busy)
    else $error("receive done while busy");

endmodule
